[rtl/lglf_pkg.sv]
package lglf_pkg;

   localparam int SAMPLE_BITS = 16;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          sample_valid;
      logic                          end_of_line;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filled_value;
      logic                          filled_ok;
      logic                          run_last;
      logic                          line_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FILL,
      ST_SELF,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic fill_init;
      logic emit_fill;
      logic emit_self;
      logic emit_flush;
   } cmd_type;

   typedef struct packed {
      logic sample_valid;
      logic gap_nz;
      logic seen;
      logic eol_now;
      logic div_busy;
      logic fill_last;
      logic out_free;
   } status_type;

endpackage

[rtl/lglf_div.sv]
module lglf_div #(
   parameter int GW = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lglf_pkg::SAMPLE_BITS-1:0]  dividend,
   input  logic [GW-1:0]                     divisor,
   output logic                              busy,
   output logic [lglf_pkg::SAMPLE_BITS-1:0]  quotient,
   output logic [GW-1:0]                     remainder
);
   import lglf_pkg::*;

   localparam int CW = $clog2(SAMPLE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [GW-1:0]          rem_ff, rem_in;
   logic [GW-1:0]          dvs_ff, dvs_in;
   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [GW:0]            shifted;
   logic [GW:0]            diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[SAMPLE_BITS-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(SAMPLE_BITS);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[GW-1:0];
            quo_in = {quo_ff[SAMPLE_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[GW-1:0];
            quo_in = {quo_ff[SAMPLE_BITS-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/lglf_dp.sv]
module lglf_dp #(
   parameter int LINE_MAX = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lglf_pkg::cmd_type    cmd,
   output lglf_pkg::status_type status,
   input  lglf_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lglf_pkg::rsp_type    rsp_data
);
   import lglf_pkg::*;

   localparam int GW = $clog2(LINE_MAX + 1);
   localparam int PW = $clog2(LINE_MAX);
   localparam int SB = SAMPLE_BITS;

   logic [SB-1:0] anchor_ff, anchor_in;
   logic          seen_ff, seen_in;
   logic [GW-1:0] gap_ff, gap_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [SB-1:0] x_ff, x_in;
   logic          eol_ff, eol_in;
   logic          neg_ff, neg_in;
   logic [GW-1:0] k_ff, k_in;
   logic [SB-1:0] q_ff, q_in;
   logic [GW-1:0] r_ff, r_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          eol_now;
   logic [SB:0]   diff_w, diff_neg;
   logic [SB-1:0] mag;
   logic          div_busy;
   logic [SB-1:0] div_quo;
   logic [GW-1:0] div_rem;
   logic [GW-1:0] m_w;
   logic [GW:0]   rsum, rsub;
   logic          carry;
   logic [SB-1:0] q_next;
   logic [GW-1:0] r_next;
   logic [SB-1:0] offs;
   logic [SB-1:0] fill_val;
   logic [SB-1:0] flush_val;
   logic          fill_last;
   logic          out_free;

   assign eol_now  = req_data.end_of_line || (pos_ff == PW'(LINE_MAX - 1));
   assign diff_w   = {req_data.sample[SB-1], req_data.sample} - {anchor_ff[SB-1], anchor_ff};
   assign diff_neg = ~diff_w + (SB+1)'(1);
   assign mag      = diff_w[SB] ? diff_neg[SB-1:0] : diff_w[SB-1:0];
   assign m_w      = gap_ff + GW'(1);

   lglf_div #(
      .GW (GW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (mag),
      .divisor   (m_w),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsum      = {1'b0, r_ff} + {1'b0, div_rem};
   assign rsub      = rsum - {1'b0, m_w};
   assign carry     = (rsum >= {1'b0, m_w});
   assign r_next    = carry ? rsub[GW-1:0] : rsum[GW-1:0];
   assign q_next    = q_ff + div_quo + SB'(carry);
   assign offs      = neg_ff ? (~q_ff + SB'(1)) : q_ff;
   assign fill_val  = seen_ff ? (anchor_ff + offs) : x_ff;
   assign flush_val = seen_ff ? anchor_ff : '0;
   assign fill_last = (k_ff == gap_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      anchor_in    = anchor_ff;
      seen_in      = seen_ff;
      gap_in       = gap_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      eol_in       = eol_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (cmd.accept) begin
         x_in   = req_data.sample;
         eol_in = eol_now;
         neg_in = diff_w[SB];
         k_in   = GW'(1);
         if (!req_data.sample_valid) begin
            gap_in = gap_ff + GW'(1);
            if (!eol_now) begin
               pos_in = pos_ff + PW'(1);
            end
         end
      end

      if (cmd.fill_init) begin
         q_in = div_quo;
         r_in = div_rem;
      end

      if (cmd.emit_fill) begin
         k_in         = k_ff + GW'(1);
         q_in         = q_next;
         r_in         = r_next;
         rsp_valid_in = 1'b1;
         rsp_in       = '{filled_value: fill_val, filled_ok: 1'b1,
                          run_last: 1'b0, line_done: 1'b0};
      end

      if (cmd.emit_self) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{filled_value: x_ff, filled_ok: 1'b1,
                          run_last: 1'b1, line_done: eol_ff};
         gap_in       = '0;
         if (eol_ff) begin
            anchor_in = '0;
            seen_in   = 1'b0;
            pos_in    = '0;
         end else begin
            anchor_in = x_ff;
            seen_in   = 1'b1;
            pos_in    = pos_ff + PW'(1);
         end
      end

      if (cmd.emit_flush) begin
         k_in         = k_ff + GW'(1);
         rsp_valid_in = 1'b1;
         rsp_in       = '{filled_value: flush_val, filled_ok: seen_ff,
                          run_last: fill_last, line_done: fill_last};
         if (fill_last) begin
            anchor_in = '0;
            seen_in   = 1'b0;
            gap_in    = '0;
            pos_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff    <= '0;
         seen_ff      <= 1'b0;
         gap_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         anchor_ff    <= anchor_in;
         seen_ff      <= seen_in;
         gap_ff       <= gap_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      eol_ff <= eol_in;
      neg_ff <= neg_in;
      k_ff   <= k_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      rsp_ff <= rsp_in;
   end

   assign status = '{sample_valid: req_data.sample_valid,
                     gap_nz:       (gap_ff != '0),
                     seen:         seen_ff,
                     eol_now:      eol_now,
                     div_busy:     div_busy,
                     fill_last:    fill_last,
                     out_free:     out_free};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/lglf_ctrl.sv]
module lglf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lglf_pkg::status_type status,
   output lglf_pkg::cmd_type    cmd
);
   import lglf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.sample_valid) begin
                  if (!status.gap_nz) begin
                     state_in = ST_SELF;
                  end else if (status.seen) begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIV;
                  end else begin
                     state_in = ST_FILL;
                  end
               end else if (status.eol_now) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               cmd.fill_init = 1'b1;
               state_in      = ST_FILL;
            end
         end
         ST_FILL: begin
            if (status.out_free) begin
               cmd.emit_fill = 1'b1;
               if (status.fill_last) begin
                  state_in = ST_SELF;
               end
            end
         end
         ST_SELF: begin
            if (status.out_free) begin
               cmd.emit_self = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit_flush = 1'b1;
               if (status.fill_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_fill, cmd.emit_self, cmd.emit_flush}))
      else $error("more than one result loaded in a cycle");

   a_fill_has_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> status.gap_nz)
      else $error("filling with no holes held back");

   a_flush_has_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> status.gap_nz)
      else $error("flushing with no holes held back");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_fill || cmd.emit_self || cmd.emit_flush) |-> status.out_free)
      else $error("result loaded over one not yet taken");

endmodule

[rtl/line_gap_linear_fill.sv]
// Fills holes in a line of signed samples by linear interpolation. Items of a line
// arrive in order; a hole gives no result until its run closes. A valid sample
// after a run of L holes is taken, passes through the one-bit-per-cycle restoring
// divider, which divides |B-A| by L+1 into a SAMPLE_BITS (16) bit quotient; its
// quotient and remainder are then loaded, and the filled run and the sample
// itself follow, one result per cycle while the output register is free; the
// filled values are built from that one quotient and remainder by accumulation.
// A hole that ends the line delivers its run without the divider.
// Without a preceding valid sample the divider is skipped. One item is worked on
// at a time; the next is taken while the last result still waits in the output
// register. A line ends at end_of_line or at its LINE_MAX-th sample.
module line_gap_linear_fill #(
   parameter int LINE_MAX = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lglf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lglf_pkg::rsp_type rsp_data
);
   import lglf_pkg::*;

   cmd_type    cmd;
   status_type status;

   lglf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lglf_dp #(
      .LINE_MAX (LINE_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[verif/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lglf_pkg::*;

   localparam int LINE_MAX   = 64;
   localparam int HOLD       = 40;
   localparam int LIMIT      = 200000;
   localparam int MAX_REPORT = 10;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type                       fill_q[$];
   logic signed [SAMPLE_BITS-1:0] ln_anchor;
   bit                            ln_seen;
   int                            ln_gap;
   int                            ln_pos;

   int send_idle;
   int recv_stall;
   int cycles;
   int mismatches;
   int items_in;
   int results_checked;
   int lines_done;

   line_gap_linear_fill #(
      .LINE_MAX(LINE_MAX)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, fill_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return SAMPLE_BITS'($urandom_range(200) - 100);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic string fmt_rsp(input rsp_type r);
      return $sformatf("val=%0d ok=%0b last=%0b done=%0b",
                       r.filled_value, r.filled_ok, r.run_last, r.line_done);
   endfunction

   task automatic fill_predict(input req_type d);
      rsp_type r;
      bit      eol;
      longint  x;
      longint  a;
      longint  v;
      int      n0;
      int      k;
      n0  = fill_q.size();
      x   = d.sample;
      a   = ln_anchor;
      eol = d.end_of_line || (ln_pos + 1 >= LINE_MAX);
      if (d.sample_valid) begin
         for (k = 1; k <= ln_gap; k++) begin
            v = ln_seen ? a + ((x - a) * k) / (ln_gap + 1) : x;
            r = '0;
            r.filled_value = v[SAMPLE_BITS-1:0];
            r.filled_ok = 1'b1;
            fill_q.push_back(r);
         end
         r = '0;
         r.filled_value = d.sample;
         r.filled_ok = 1'b1;
         fill_q.push_back(r);
         ln_anchor = d.sample;
         ln_seen = 1'b1;
         ln_gap = 0;
      end else begin
         ln_gap++;
         if (eol) begin
            for (k = 0; k < ln_gap; k++) begin
               r = '0;
               r.filled_value = ln_seen ? ln_anchor : '0;
               r.filled_ok = ln_seen;
               fill_q.push_back(r);
            end
         end
      end
      if (fill_q.size() > n0) begin
         r = fill_q.pop_back();
         r.run_last = 1'b1;
         r.line_done = eol;
         fill_q.push_back(r);
      end
      if (eol) begin
         ln_anchor = '0;
         ln_seen = 1'b0;
         ln_gap = 0;
         ln_pos = 0;
      end else begin
         ln_pos++;
      end
   endtask

   task automatic check_fill(input rsp_type got);
      rsp_type want;
      if (fill_q.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORT)
            $display("unexpected item: got %s", fmt_rsp(got));
      end else begin
         want = fill_q.pop_front();
         results_checked++;
         if (want.line_done)
            lines_done++;
         if (got.filled_value !== want.filled_value || got.filled_ok !== want.filled_ok ||
             got.run_last !== want.run_last || got.line_done !== want.line_done) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
               $display("mismatch at result %0d: expected %s, got %s",
                        results_checked, fmt_rsp(want), fmt_rsp(got));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            fill_predict(req_data);
            items_in++;
         end
         if (rsp_valid && rsp_ready)
            check_fill(rsp_data);
      end
   end

   task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s, input bit v, input bit e);
      req_type d;
      d.sample = s;
      d.sample_valid = v;
      d.end_of_line = e;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         req_data <= req_type'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (fill_q.size() != 0)
         @(posedge clock);
      repeat (HOLD) @(posedge clock);
   endtask

   task automatic test_extremes();
      send_item(16'sh8000, 1'b1, 1'b0);
      send_item(rand_sample(), 1'b0, 1'b0);
      send_item(rand_sample(), 1'b0, 1'b0);
      send_item(16'sh7fff, 1'b1, 1'b0);
      send_item(16'sh7fff, 1'b0, 1'b0);
      send_item(16'sh8000, 1'b1, 1'b1);
   endtask

   task automatic test_truncation();
      send_item(16'sd10, 1'b1, 1'b0);
      send_item(16'sh7fff, 1'b0, 1'b0);
      send_item(16'sh8000, 1'b0, 1'b0);
      send_item(16'sd0, 1'b1, 1'b0);
      send_item(-16'sd1, 1'b0, 1'b0);
      send_item(16'sd1, 1'b1, 1'b1);
   endtask

   task automatic test_start_gap();
      send_item(16'sh5555, 1'b0, 1'b0);
      send_item(16'shaaaa, 1'b0, 1'b0);
      send_item(16'sd100, 1'b1, 1'b0);
      send_item(-16'sd7, 1'b1, 1'b1);
   endtask

   task automatic test_end_gap();
      send_item(-16'sd300, 1'b1, 1'b0);
      send_item(16'sh7fff, 1'b0, 1'b0);
      send_item(16'sh0000, 1'b0, 1'b0);
      send_item(16'sh8000, 1'b0, 1'b1);
   endtask

   task automatic test_empty_line();
      send_item(16'shffff, 1'b0, 1'b0);
      send_item(16'sh1234, 1'b0, 1'b0);
      send_item(16'sh8001, 1'b0, 1'b1);
      send_item(16'sh7ffe, 1'b0, 1'b1);
      send_item(16'sh8000, 1'b1, 1'b1);
   endtask

   task automatic test_overlong_line();
      int i;
      for (i = 0; i < LINE_MAX; i++)
         send_item(rand_sample(), 1'b0, 1'b0);
   endtask

   task automatic test_random_lines(input int idle, input int stall, input int count);
      int sent;
      int len;
      int hole_pct;
      int i;
      bit v;
      bit e;
      send_idle = idle;
      recv_stall = stall;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(12, 1);
         hole_pct = $urandom_range(90);
         for (i = 0; i < len; i++) begin
            v = ($urandom_range(99) >= hole_pct);
            e = (i == len - 1) || ($urandom_range(24) == 0);
            send_item(rand_sample(), v, e);
         end
         sent += len;
      end
      send_item(rand_sample(), 1'b1, 1'b1);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      send_idle = 0;
      recv_stall = 0;
      cycles = 0;
      mismatches = 0;
      items_in = 0;
      results_checked = 0;
      lines_done = 0;
      ln_anchor = '0;
      ln_seen = 1'b0;
      ln_gap = 0;
      ln_pos = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_truncation();
      test_start_gap();
      test_end_gap();
      test_empty_line();
      wait_drained();

      recv_stall = 46;
      test_overlong_line();
      wait_drained();

      test_random_lines(0, 0, 15);
      test_random_lines(46, 0, 15);
      wait_drained();
      test_random_lines(0, 46, 15);
      test_random_lines(9, 9, 15);
      wait_drained();

      $display("covered %0d items over %0d lines, %0d results checked, %0d mismatches",
               items_in, lines_done, results_checked, mismatches);
      $display("included interior, leading and trailing gaps, empty and overlong lines");
      if (mismatches == 0 && fill_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
